// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the current-sense averaging core.
// Both forms sample on the rising clock edge and hold off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define CSAC_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// An antecedent that, when true, requires the consequent in the same cycle.
`define CSAC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/csac_pkg.sv =====
// Shared types, register indexes, reset values and constants of the
// current-sense averaging core. No dependencies.
`timescale 1ns / 1ps

package csac_pkg;

    localparam int CSAC_WINDOW_LEN  = 10;
    localparam int CSAC_SAMPLE_BITS = 12;

    localparam int CFG_W      = 16;
    localparam int DIGIT_W    = 16;
    localparam int OUT_W      = 25;
    localparam int OUT_MAX    = 16777215;
    localparam int OUT_MIN    = -16777216;
    localparam int ROUND_HALF = 128;
    localparam int REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0]    t_reg_idx;
    typedef logic [CFG_W-1:0]        t_cfg;
    typedef logic signed [CFG_W-1:0] t_coef;
    typedef logic signed [OUT_W-1:0] t_amps;

    localparam t_reg_idx REG_SCALE     = 3'd0;
    localparam t_reg_idx REG_THRESHOLD = 3'd1;
    localparam t_reg_idx REG_COEF_A    = 3'd2;
    localparam t_reg_idx REG_COEF_B    = 3'd3;
    localparam t_reg_idx REG_COEF_C    = 3'd4;

    localparam t_cfg  RST_SCALE     = 16'd2641;
    localparam t_cfg  RST_THRESHOLD = 16'd640;
    localparam t_coef RST_COEF_A    = 16'sd292;
    localparam t_coef RST_COEF_B    = -16'sd1628;
    localparam t_coef RST_COEF_C    = 16'sd3017;

endpackage

// ===== rtl/core/csac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module csac_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/csac_div.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
// No dependencies.
`timescale 1ns / 1ps

module csac_div #(
    parameter int DW = 32,
    parameter int VW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quotient,
    output logic          o_done
);

    localparam int DWP   = DW + (DW % 2);
    localparam int STEPS = DWP / 2;
    localparam int CW    = $clog2(STEPS + 1);

    logic [DWP-1:0] r_q;
    logic [VW-1:0]  r_rem;
    logic [VW-1:0]  r_div;
    logic [CW-1:0]  r_cnt;
    logic           r_done;

    logic [VW:0]   w_t1;
    logic [VW:0]   w_t2;
    logic          w_ge1;
    logic          w_ge2;
    logic [VW-1:0] w_rem1;
    logic [VW-1:0] w_rem2;

    // Two dependent trial subtractions on the narrow partial remainder.
    always_comb begin
        w_t1   = {r_rem, r_q[DWP-1]};
        w_ge1  = (w_t1 >= {1'b0, r_div});
        w_rem1 = w_ge1 ? VW'(w_t1 - {1'b0, r_div}) : VW'(w_t1);
        w_t2   = {w_rem1, r_q[DWP-2]};
        w_ge2  = (w_t2 >= {1'b0, r_div});
        w_rem2 = w_ge2 ? VW'(w_t2 - {1'b0, r_div}) : VW'(w_t2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= DWP'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_q   <= {r_q[DWP-3:0], w_ge1, w_ge2};
            r_rem <= w_rem2;
        end
    end

    assign o_quotient = r_q[DW-1:0];
    assign o_done     = r_done;

endmodule

// ===== rtl/core/current_sense_average_calibrate_top.sv =====
// Current-sense averaging and calibration core. Each input transfer carries one supply and
// one battery ADC count; each output transfer returns both channels as signed Q16.8 amps,
// saturated to 25 bits. Each channel is averaged over the last WINDOW_LEN samples (over all
// samples seen so far while the window fills), scaled by count_to_amps_scale, and, when the
// Q8.8 average exceeds calibration_threshold, corrected by a*m^2 + b*m + c. The block takes
// one item at a time: o_ready is high only while idle, and a finished result waits in the
// output register, so the next item is taken while it waits. An item occupies the core
// longer when one channel is corrected and longer still when both are. At default
// parameters the time is set by the 16-step radix-4 divider that divides the scaled
// sum by the fill count, once per channel, and by the single shared 17 x 26 bit
// multiplier, which builds m*m and a*m^2 from 16-bit digits over several passes. Samples are
// kept in one RAM of WINDOW_LEN words that holds both channels; a running sum per channel is
// updated by reading the entry about to be overwritten. Configuration writes take effect at
// once and are meant to be made while the core is idle. There is no clearing pass after reset.
// Depends on csac_pkg, csac_ram, csac_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module current_sense_average_calibrate_top
    import csac_pkg::*;
#(
    parameter int WINDOW_LEN  = CSAC_WINDOW_LEN,
    parameter int SAMPLE_BITS = CSAC_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  t_reg_idx               i_cfg_index,
    input  t_cfg                   i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [SAMPLE_BITS-1:0] i_supply_sample,
    input  logic [SAMPLE_BITS-1:0] i_battery_sample,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_amps                  o_supply_amps,
    output t_amps                  o_battery_amps
);

    // Width plan. The sum of a full window fits SW bits; the Q8.8 average fits MW bits and
    // its rounded square SQW bits. The accumulator holds a*sq + b*m + c*256 without overflow.
    localparam int FW        = $clog2(WINDOW_LEN + 1);
    localparam int AW        = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int SW        = SAMPLE_BITS + FW;
    localparam int DW        = SW + CFG_W;
    localparam int MW        = SW + 9;
    localparam int XW        = CFG_W + 1;
    localparam int YW        = MW + 1;
    localparam int PW        = XW + YW;
    localparam int SQW       = 2 * MW - 8;
    localparam int ACCW      = SQW + 17;
    localparam int RW        = ACCW - 8;
    localparam int M_DIGITS  = (MW + DIGIT_W - 1) / DIGIT_W;
    localparam int SQ_DIGITS = (SQW + DIGIT_W - 1) / DIGIT_W;
    localparam int MPW       = M_DIGITS * DIGIT_W;
    localparam int SQPW      = SQ_DIGITS * DIGIT_W;
    localparam int KW        = $clog2(SQ_DIGITS);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_RD        = 4'd1;
    localparam logic [3:0] S_MUL_SCALE = 4'd2;
    localparam logic [3:0] S_DIV_START = 4'd3;
    localparam logic [3:0] S_DIV_WAIT  = 4'd4;
    localparam logic [3:0] S_CMP       = 4'd5;
    localparam logic [3:0] S_SQ_MUL    = 4'd6;
    localparam logic [3:0] S_SQ_ACC    = 4'd7;
    localparam logic [3:0] S_SQ_RND    = 4'd8;
    localparam logic [3:0] S_A_MUL     = 4'd9;
    localparam logic [3:0] S_A_ACC     = 4'd10;
    localparam logic [3:0] S_B_MUL     = 4'd11;
    localparam logic [3:0] S_B_ACC     = 4'd12;
    localparam logic [3:0] S_FIN       = 4'd13;
    localparam logic [3:0] S_DONE      = 4'd14;

    // Control state.
    logic [3:0]    r_state, n_state;
    logic          r_ch, n_ch;
    logic [KW-1:0] r_k, n_k;
    logic [FW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_slot, n_slot;
    logic [SW-1:0] r_sum [2];
    logic [SW-1:0] n_sum [2];
    logic          r_out_valid, n_out_valid;

    // Configuration registers.
    t_cfg  r_scale;
    t_cfg  r_thr;
    t_coef r_coef_a;
    t_coef r_coef_b;
    t_coef r_coef_c;

    // Datapath registers.
    logic [SAMPLE_BITS-1:0] r_new_s;
    logic [SAMPLE_BITS-1:0] r_new_b;
    logic signed [PW-1:0]   r_prod;
    logic [MW-1:0]          r_m;
    logic [SQW-1:0]         r_sq;
    logic signed [ACCW-1:0] r_acc;
    t_amps                  r_res [2];
    t_amps                  r_out_s;
    t_amps                  r_out_b;

    logic                     w_in_xfer;
    logic                     w_out_xfer;
    logic                     w_full;
    logic [2*SAMPLE_BITS-1:0] w_ram_rdata;
    logic [SAMPLE_BITS-1:0]   w_old_s;
    logic [SAMPLE_BITS-1:0]   w_old_b;
    logic                     w_div_start;
    logic [DW-1:0]            w_quot;
    logic                     w_div_done;
    logic [DW:0]              w_q_rnd;
    logic                     w_m_gt;
    logic [MPW-1:0]           w_m_pad;
    logic [SQPW-1:0]          w_sq_pad;
    logic signed [XW-1:0]     w_mul_x;
    logic signed [YW-1:0]     w_mul_y;
    logic signed [PW-1:0]     w_prod;
    logic signed [ACCW-1:0]   w_prod_ext;
    logic signed [ACCW-1:0]   w_prod_sh;
    logic signed [ACCW-1:0]   w_acc_rnd;
    logic signed [RW-1:0]     w_sat_in;
    t_amps                    w_sat;

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = r_out_valid && i_ready;

    // The entry at the write slot holds a live sample only once the window is full;
    // while it fills, the slot still points at an entry that was never written.
    assign w_full  = (r_fill == FW'(WINDOW_LEN));
    assign w_old_s = w_full ? w_ram_rdata[SAMPLE_BITS-1:0] : '0;
    assign w_old_b = w_full ? w_ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS] : '0;

    // Both channels share one sample RAM. The old entry is read on the transfer edge and
    // the new pair is written over it in the following cycle.
    csac_ram #(
        .WIDTH (2 * SAMPLE_BITS),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_state == S_RD),
        .i_waddr (r_slot),
        .i_wdata ({r_new_b, r_new_s}),
        .i_re    (w_in_xfer),
        .i_raddr (r_slot),
        .o_rdata (w_ram_rdata)
    );

    // Scaled sum divided by the fill count gives the average in Q.16.
    assign w_div_start = (r_state == S_DIV_START);

    csac_div #(
        .DW (DW),
        .VW (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod[DW-1:0]),
        .i_divisor  (r_fill),
        .o_quotient (w_quot),
        .o_done     (w_div_done)
    );

    // Round Q.16 to Q8.8, half up.
    assign w_q_rnd = {1'b0, w_quot} + (DW + 1)'(ROUND_HALF);
    assign w_m_gt  = (r_m > MW'(r_thr));

    assign w_m_pad  = MPW'(r_m);
    assign w_sq_pad = SQPW'(r_sq);

    // Operand selection for the shared multiplier. Wide operands are fed as unsigned
    // 16-bit digits; the accumulator adds each partial product at its digit weight.
    always_comb begin
        unique case (r_state)
            S_MUL_SCALE: begin
                w_mul_x = $signed({1'b0, r_scale});
                w_mul_y = $signed(YW'(r_sum[r_ch]));
            end
            S_SQ_MUL: begin
                w_mul_x = $signed({1'b0, w_m_pad[r_k*DIGIT_W +: DIGIT_W]});
                w_mul_y = $signed(YW'(r_m));
            end
            S_A_MUL: begin
                w_mul_x = $signed({1'b0, w_sq_pad[r_k*DIGIT_W +: DIGIT_W]});
                w_mul_y = YW'(r_coef_a);
            end
            S_B_MUL: begin
                w_mul_x = XW'(r_coef_b);
                w_mul_y = $signed(YW'(r_m));
            end
            default: begin
                w_mul_x = '0;
                w_mul_y = '0;
            end
        endcase
    end

    assign w_prod     = w_mul_x * w_mul_y;
    assign w_prod_ext = ACCW'(r_prod);
    assign w_prod_sh  = w_prod_ext <<< (r_k * DIGIT_W);
    assign w_acc_rnd  = r_acc + ACCW'(ROUND_HALF);

    // The corrected value is floor((P + 128) / 256); an uncorrected average passes as is.
    assign w_sat_in = (r_state == S_FIN) ? $signed(w_acc_rnd[ACCW-1:8])
                                         : $signed(RW'(r_m));

    always_comb begin
        priority if (w_sat_in > RW'(OUT_MAX)) begin
            w_sat = t_amps'(OUT_MAX);
        end else if (w_sat_in < RW'(OUT_MIN)) begin
            w_sat = t_amps'(OUT_MIN);
        end else begin
            w_sat = w_sat_in[OUT_W-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_ch        = r_ch;
        n_k         = r_k;
        n_fill      = r_fill;
        n_slot      = r_slot;
        n_sum[0]    = r_sum[0];
        n_sum[1]    = r_sum[1];
        n_out_valid = r_out_valid;
        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_sum[0] = r_sum[0] + SW'(r_new_s) - SW'(w_old_s);
                n_sum[1] = r_sum[1] + SW'(r_new_b) - SW'(w_old_b);
                if (!w_full) begin
                    n_fill = r_fill + FW'(1);
                end
                n_slot  = (r_slot == AW'(WINDOW_LEN - 1)) ? '0 : r_slot + AW'(1);
                n_ch    = 1'b0;
                n_state = S_MUL_SCALE;
            end
            S_MUL_SCALE: n_state = S_DIV_START;
            S_DIV_START: n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (w_m_gt) begin
                    n_k     = '0;
                    n_state = S_SQ_MUL;
                end else if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_state = S_MUL_SCALE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: begin
                if (r_k == KW'(M_DIGITS - 1)) begin
                    n_k     = '0;
                    n_state = S_SQ_RND;
                end else begin
                    n_k     = r_k + KW'(1);
                    n_state = S_SQ_MUL;
                end
            end
            S_SQ_RND: n_state = S_A_MUL;
            S_A_MUL:  n_state = S_A_ACC;
            S_A_ACC: begin
                if (r_k == KW'(SQ_DIGITS - 1)) begin
                    n_k     = '0;
                    n_state = S_B_MUL;
                end else begin
                    n_k     = r_k + KW'(1);
                    n_state = S_A_MUL;
                end
            end
            S_B_MUL: n_state = S_B_ACC;
            S_B_ACC: n_state = S_FIN;
            S_FIN: begin
                if (!r_ch) begin
                    n_ch    = 1'b1;
                    n_state = S_MUL_SCALE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= 1'b0;
            r_k         <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ch        <= n_ch;
            r_k         <= n_k;
            r_fill      <= n_fill;
            r_slot      <= n_slot;
            r_sum[0]    <= n_sum[0];
            r_sum[1]    <= n_sum[1];
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration writes; indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= RST_SCALE;
            r_thr    <= RST_THRESHOLD;
            r_coef_a <= RST_COEF_A;
            r_coef_b <= RST_COEF_B;
            r_coef_c <= RST_COEF_C;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SCALE:     r_scale  <= i_cfg_wdata;
                REG_THRESHOLD: r_thr    <= i_cfg_wdata;
                REG_COEF_A:    r_coef_a <= $signed(i_cfg_wdata);
                REG_COEF_B:    r_coef_b <= $signed(i_cfg_wdata);
                REG_COEF_C:    r_coef_c <= $signed(i_cfg_wdata);
                default: ;
            endcase
        end
    end

    // Datapath.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (w_in_xfer) begin
            r_new_s <= i_supply_sample;
            r_new_b <= i_battery_sample;
        end
        unique case (r_state)
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    r_m <= w_q_rnd[DW:8];
                end
            end
            S_CMP: begin
                r_acc <= '0;
                if (!w_m_gt) begin
                    r_res[r_ch] <= w_sat;
                end
            end
            S_SQ_ACC, S_A_ACC, S_B_ACC: begin
                r_acc <= r_acc + w_prod_sh;
            end
            S_SQ_RND: begin
                r_sq  <= w_acc_rnd[SQW+7:8];
                r_acc <= ACCW'(r_coef_c) <<< 8;
            end
            S_FIN: begin
                r_res[r_ch] <= w_sat;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    r_out_s <= r_res[0];
                    r_out_b <= r_res[1];
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_supply_amps  = r_out_s;
    assign o_battery_amps = r_out_b;

    // The fill count never passes the window length.
    `CSAC_ASSERT_CLK(a_fill_bound, i_clk, i_rst_n, r_fill <= FW'(WINDOW_LEN), "fill count beyond window")
    // While the window fills, the write slot tracks the fill count.
    `CSAC_ASSERT_IMPL(a_slot_tracks_fill, i_clk, i_rst_n, !w_full, FW'(r_slot) == r_fill, "write slot and fill count disagree")
    // The divider finishes only while the sequencer waits for it.
    `CSAC_ASSERT_IMPL(a_div_done_wait, i_clk, i_rst_n, w_div_done, r_state == S_DIV_WAIT, "divider result arrived outside its wait state")
    // The fill count moves only together with a write to the sample RAM.
    `CSAC_ASSERT_IMPL(a_fill_after_write, i_clk, i_rst_n, $past(i_rst_n) && (r_fill != $past(r_fill)), $past(r_state) == S_RD, "fill count changed without a window write")

endmodule
